@@ design/config_text_tokenizer_top_defines.svh @@
// ---------------------------------------------------------------------------
// config_text_tokenizer_top_defines.svh
// Assertion macros used by the tokenizer scanner RTL.
// ---------------------------------------------------------------------------
`ifndef CONFIG_TEXT_TOKENIZER_TOP_DEFINES_SVH
`define CONFIG_TEXT_TOKENIZER_TOP_DEFINES_SVH

// cond in a cycle implies cons in the same cycle
`define CTT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cond in a cycle implies cons in the next cycle
`define CTT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// cond never holds
`define CTT_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

@@ design/cfgtok_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfgtok_pkg
// Character codes, byte classes, token kinds, error codes and beat types of the tokenizer.
// ---------------------------------------------------------------------------
package cfgtok_pkg;

	// characters
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_I   = 8'h49;
	localparam logic [7:0] CH_UC_J   = 8'h4A;
	localparam logic [7:0] CH_UC_S   = 8'h53;
	localparam logic [7:0] CH_UC_Z   = 8'h5A;
	localparam logic [7:0] CH_LSQ    = 8'h5B;
	localparam logic [7:0] CH_RSQ    = 8'h5D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// byte classes
	localparam logic [3:0] CLS_SPACE  = 4'd0;
	localparam logic [3:0] CLS_PUNCT  = 4'd1;
	localparam logic [3:0] CLS_QUOTE  = 4'd2;
	localparam logic [3:0] CLS_MINUS  = 4'd3;
	localparam logic [3:0] CLS_DIGIT  = 4'd4;
	localparam logic [3:0] CLS_LETTER = 4'd5;
	localparam logic [3:0] CLS_UNDER  = 4'd6;
	localparam logic [3:0] CLS_ZERO   = 4'd7;
	localparam logic [3:0] CLS_OTHER  = 4'd8;

	// token kinds
	localparam logic [3:0] K_LBRACE  = 4'd0;
	localparam logic [3:0] K_RBRACE  = 4'd1;
	localparam logic [3:0] K_COLON   = 4'd2;
	localparam logic [3:0] K_COMMA   = 4'd3;
	localparam logic [3:0] K_LSQUARE = 4'd4;
	localparam logic [3:0] K_RSQUARE = 4'd5;
	localparam logic [3:0] K_STRING  = 4'd6;
	localparam logic [3:0] K_IDENT   = 4'd7;
	localparam logic [3:0] K_NUMBER  = 4'd8;
	localparam logic [3:0] K_END     = 4'd9;
	localparam logic [3:0] K_TRUE    = 4'd10;
	localparam logic [3:0] K_FALSE   = 4'd11;
	localparam logic [3:0] K_NULL    = 4'd12;
	localparam logic [3:0] K_STRTYPE = 4'd13;
	localparam logic [3:0] K_INTTYPE = 4'd14;

	// error codes
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_UNTERM  = 2'd1;
	localparam logic [1:0] ERR_MINUS   = 2'd2;

	localparam int LEN_LIMIT    = 4095;
	localparam int ITEM_Q_DEPTH = 2;
	localparam int RES_Q_DEPTH  = 4;

	// classified byte, front to back
	typedef struct packed {
		logic [3:0] cls;
		logic [3:0] kind;   // punctuation kind, or identifier kind of a letter
		logic       eot;
	} item_t;

	// one result beat
	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] start;
		logic [11:0] length;
		logic [1:0]  err;
		logic        last;
	} result_t;

endpackage

@@ design/cfgtok_fifo.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfgtok_fifo
// Small register queue with push/full and pop/empty sides.
// ---------------------------------------------------------------------------
module cfgtok_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/cfgtok_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfgtok_front
// Input stage: takes text beats, classifies each byte and registers it.
// ---------------------------------------------------------------------------
module cfgtok_front import cfgtok_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       end_of_text,
	output item_t      item,
	output logic       item_valid,
	input  logic       item_ready
);

	logic  valid_s1;
	item_t item_s1;
	item_t cls_d;

	assign full       = valid_s1 && !item_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	// byte class and kind
	always_comb begin
		cls_d.eot  = end_of_text;
		cls_d.kind = K_IDENT;
		cls_d.cls  = CLS_OTHER;
		if (end_of_text) begin
			cls_d.cls = CLS_ZERO;
		end else begin
			case (data_byte) inside
				CH_SPACE, CH_NL: cls_d.cls = CLS_SPACE;
				CH_NUL:          cls_d.cls = CLS_ZERO;
				CH_QUOTE:        cls_d.cls = CLS_QUOTE;
				CH_MINUS:        cls_d.cls = CLS_MINUS;
				CH_UNDER:        cls_d.cls = CLS_UNDER;
				CH_LBRACE: begin
					cls_d.cls  = CLS_PUNCT;
					cls_d.kind = K_LBRACE;
				end
				CH_RBRACE: begin
					cls_d.cls  = CLS_PUNCT;
					cls_d.kind = K_RBRACE;
				end
				CH_LSQ: begin
					cls_d.cls  = CLS_PUNCT;
					cls_d.kind = K_LSQUARE;
				end
				CH_RSQ: begin
					cls_d.cls  = CLS_PUNCT;
					cls_d.kind = K_RSQUARE;
				end
				CH_COLON: begin
					cls_d.cls  = CLS_PUNCT;
					cls_d.kind = K_COLON;
				end
				CH_COMMA: begin
					cls_d.cls  = CLS_PUNCT;
					cls_d.kind = K_COMMA;
				end
				[CH_0:CH_9]: cls_d.cls = CLS_DIGIT;
				[CH_UC_A:CH_UC_Z], [CH_LC_A:CH_LC_Z]: begin
					cls_d.cls = CLS_LETTER;
					case (data_byte)
						CH_UC_I: cls_d.kind = K_INTTYPE;
						CH_UC_S: cls_d.kind = K_STRTYPE;
						CH_UC_J: cls_d.kind = K_NULL;
						CH_LC_T: cls_d.kind = K_TRUE;
						CH_LC_F: cls_d.kind = K_FALSE;
						default: cls_d.kind = K_IDENT;
					endcase
				end
				default: cls_d.cls = CLS_OTHER;
			endcase
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= push;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (push && !full) begin
			item_s1 <= cls_d;
		end
	end

endmodule

@@ design/cfgtok_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfgtok_back
// Scanner: runs the token state machine on classified bytes, one a cycle
// when not stalled by a held beat or a full result queue, and writes result
// beats to the result queue.
`include "config_text_tokenizer_top_defines.svh"

module cfgtok_back import cfgtok_pkg::*; #(
	parameter int MAX_TOKEN_LENGTH = 4095,
	parameter int MAX_TEXT_LENGTH  = 65536
) (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  logic    item_valid,
	output logic    item_ready,
	output logic    res_push,
	output result_t res_data,
	input  logic    res_full
);

	localparam int OFF_W = $clog2(MAX_TEXT_LENGTH + 1);
	localparam logic [11:0] LEN_CAP =
		12'((MAX_TOKEN_LENGTH < LEN_LIMIT) ? MAX_TOKEN_LENGTH : LEN_LIMIT);
	localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_TEXT_LENGTH);

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_STRING = 3'd1;
	localparam logic [2:0] MODE_NUMBER = 3'd2;
	localparam logic [2:0] MODE_IDENT  = 3'd3;
	localparam logic [2:0] MODE_DRAIN  = 3'd4;
	localparam logic [2:0] MODE_HALT   = 3'd5;

	logic [2:0]       mode_q;
	logic [OFF_W-1:0] off_q;
	logic [15:0]      begin_q;
	logic [11:0]      len_q;
	logic [3:0]       kind_q;
	logic             minus_q;
	logic             pend_q;
	result_t          pend_res_q;

	logic             take;
	logic             over;
	logic [3:0]       cls;
	logic [31:0]      pos32;
	logic [15:0]      pos16;
	logic [11:0]      len_inc;

	// scan of a byte between tokens
	logic             ir_v;
	result_t          ir;
	logic [2:0]       imode;
	logic             istart;
	logic             iclr;

	logic             r0_v;
	logic             r1_v;
	logic             use_idle;
	result_t          r0;
	result_t          r1;
	logic [2:0]       mode_d;
	logic [OFF_W-1:0] off_d;
	logic [15:0]      begin_d;
	logic [11:0]      len_d;
	logic [3:0]       kind_d;
	logic             minus_d;

	assign item_ready = !pend_q && !res_full;
	assign take       = item_valid && item_ready;
	assign over       = (off_q >= OFF_MAX);
	assign cls        = over ? CLS_ZERO : item.cls;
	assign pos32      = 32'(off_q);
	assign pos16      = pos32[15:0];
	assign len_inc    = (len_q < LEN_CAP) ? len_q + 12'd1 : len_q;

	// byte scanned as a token start
	always_comb begin
		ir_v      = 1'b0;
		ir.kind   = item.kind;
		ir.start  = pos16;
		ir.length = 12'd1;
		ir.err    = ERR_NONE;
		ir.last   = 1'b1;
		imode     = MODE_IDLE;
		istart    = 1'b0;
		iclr      = 1'b0;
		case (cls)
			CLS_SPACE: ;
			CLS_PUNCT: ir_v = 1'b1;
			CLS_QUOTE: begin
				imode  = MODE_STRING;
				istart = 1'b1;
			end
			CLS_MINUS, CLS_DIGIT: begin
				imode  = MODE_NUMBER;
				istart = 1'b1;
			end
			CLS_LETTER: begin
				imode  = MODE_IDENT;
				istart = 1'b1;
			end
			default: begin
				ir_v      = 1'b1;
				ir.kind   = K_END;
				ir.length = 12'd0;
				if (item.eot) begin
					iclr = 1'b1;
				end else begin
					imode = MODE_DRAIN;
				end
			end
		endcase
	end

	// token state machine
	always_comb begin
		r0_v      = 1'b0;
		r1_v      = 1'b0;
		use_idle  = 1'b0;
		r0.kind   = K_STRING;
		r0.start  = begin_q;
		r0.length = len_q;
		r0.err    = ERR_NONE;
		r0.last   = 1'b1;
		r1        = ir;
		mode_d    = mode_q;
		begin_d   = begin_q;
		len_d     = len_q;
		kind_d    = kind_q;
		minus_d   = minus_q;
		off_d     = (!item.eot && !over) ? off_q + 1'b1 : off_q;
		case (mode_q)
			MODE_HALT: off_d = off_q;
			MODE_DRAIN: begin
				off_d = off_q;
				if (item.eot) begin
					off_d  = '0;
					mode_d = MODE_IDLE;
				end
			end
			MODE_STRING: begin
				if (cls == CLS_QUOTE) begin
					len_d     = len_inc;
					r0_v      = 1'b1;
					r0.length = len_inc;
					mode_d    = MODE_IDLE;
				end else if (cls == CLS_ZERO) begin
					r0_v   = 1'b1;
					r0.err = ERR_UNTERM;
					mode_d = MODE_HALT;
				end else begin
					len_d = len_inc;
				end
			end
			MODE_NUMBER: begin
				r0.kind = K_NUMBER;
				if (cls == CLS_DIGIT) begin
					len_d = len_inc;
				end else if (len_q == 12'd1 && minus_q) begin
					r0_v   = 1'b1;
					r0.err = ERR_MINUS;
					mode_d = MODE_HALT;
				end else begin
					r0_v     = 1'b1;
					use_idle = 1'b1;
					r1_v     = ir_v;
				end
			end
			MODE_IDENT: begin
				r0.kind = kind_q;
				if (cls == CLS_LETTER || cls == CLS_UNDER) begin
					len_d = len_inc;
				end else begin
					r0_v     = 1'b1;
					use_idle = 1'b1;
					r1_v     = ir_v;
				end
			end
			default: begin
				r0_v     = ir_v;
				r0       = ir;
				use_idle = 1'b1;
			end
		endcase
		if (use_idle) begin
			mode_d = imode;
			if (istart) begin
				begin_d = pos16;
				len_d   = 12'd1;
				kind_d  = item.kind;
				minus_d = (cls == CLS_MINUS);
			end
			if (iclr) begin
				off_d = '0;
			end
		end
		r0.last = !r1_v;
	end

	// result beats: a byte's second result is held and written before the next byte is taken
	assign res_push = pend_q ? !res_full : (take && r0_v);
	assign res_data = pend_q ? pend_res_q : r0;

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			off_q   <= '0;
			begin_q <= '0;
			len_q   <= '0;
			kind_q  <= K_IDENT;
			minus_q <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			if (take) begin
				mode_q  <= mode_d;
				off_q   <= off_d;
				begin_q <= begin_d;
				len_q   <= len_d;
				kind_q  <= kind_d;
				minus_q <= minus_d;
				pend_q  <= r0_v && r1_v;
			end else if (pend_q && !res_full) begin
				pend_q <= 1'b0;
			end
		end
	end

	// held second result
	always_ff @(posedge clk) begin
		if (take && r1_v) begin
			pend_res_q <= r1;
		end
	end

	`CTT_ASSERT_NXT(a_halt_sticky, mode_q == MODE_HALT, mode_q == MODE_HALT, "halt left before reset")
	`CTT_ASSERT_NEVER(a_push_room, res_push && res_full, "result beat written to a full queue")
	`CTT_ASSERT_NEVER(a_off_bound, off_q > OFF_MAX, "byte offset past text limit")
	`CTT_ASSERT_IMP(a_drain_silent, take && mode_q == MODE_DRAIN, !res_push, "result while dropping")

endmodule

@@ design/config_text_tokenizer_top.sv @@
`timescale 1ns / 1ps
// A byte beat accepted on the input side passes the input stage register, the item queue
// and the result queue before its first result shows; a second result of it follows.
// Throughput: one byte per cycle while the result queue has room; a byte that closes a
// number or identifier and also emits a token stalls the scanner for its second beat.
// Reset: arst_n clears all control state at once; no clearing pass, ready right after.
// ---------------------------------------------------------------------------
// config_text_tokenizer_top
// Streaming text tokenizer: input stage, item queue, scanner, result queue.
// ---------------------------------------------------------------------------
module config_text_tokenizer_top import cfgtok_pkg::*; #(
	parameter int MAX_TOKEN_LENGTH = 4095,
	parameter int MAX_TEXT_LENGTH  = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_text,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  token_kind,
	output logic [15:0] token_start,
	output logic [11:0] token_len,
	output logic [1:0]  error_code,
	output logic        last_of_run
);

	localparam int ITEM_W = $bits(item_t);
	localparam int RES_W  = $bits(result_t);

	item_t   front_item;
	logic    front_valid;
	logic    iq_full;
	logic    iq_empty;
	item_t   back_item;
	logic    back_ready;
	logic    res_push;
	result_t res_wr;
	logic    res_full;
	result_t res_rd;

	cfgtok_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.end_of_text (end_of_text),
		.item        (front_item),
		.item_valid  (front_valid),
		.item_ready  (!iq_full)
	);

	cfgtok_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (ITEM_Q_DEPTH)
	) u_item_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_valid),
		.wr_data (front_item),
		.full    (iq_full),
		.rd_en   (back_ready),
		.rd_data (back_item),
		.empty   (iq_empty)
	);

	cfgtok_back #(
		.MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH),
		.MAX_TEXT_LENGTH  (MAX_TEXT_LENGTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (back_item),
		.item_valid (!iq_empty),
		.item_ready (back_ready),
		.res_push   (res_push),
		.res_data   (res_wr),
		.res_full   (res_full)
	);

	cfgtok_fifo #(
		.WIDTH (RES_W),
		.DEPTH (RES_Q_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_wr),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_rd),
		.empty   (empty)
	);

	// result beat fields
	assign token_kind   = res_rd.kind;
	assign token_start  = res_rd.start;
	assign token_len    = res_rd.length;
	assign error_code   = res_rd.err;
	assign last_of_run  = res_rd.last;

endmodule

@@ test/config_text_tokenizer_top_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// config_text_tokenizer_top_test
// Self-checking bench for the text tokenizer. Feeds directed and random text
// byte beats, predicts each token beat, and compares it with what the block
// pops out. The bench covers end markers, zero and high bytes and dropped
// text. The run ends on one of the two halting errors, chosen by the seed.
// ---------------------------------------------------------------------------
module config_text_tokenizer_top_test;
	import cfgtok_pkg::*;

	localparam int TEXT_LIMIT    = 65536;
	localparam int TOKEN_LEN_CAP = 4095;
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 12;

	typedef enum logic [2:0] {
		ST_IDLE, ST_STRING, ST_NUMBER, ST_WORD, ST_SKIP, ST_STOPPED
	} scan_state_t;

	// token predictor and expected-token store
	class token_scoreboard;
		scan_state_t mode = ST_IDLE;
		int unsigned offset = 0;
		int unsigned tok_begin = 0;
		int unsigned run_len = 0;
		logic [7:0] first_char = 8'h00;
		result_t expected_q[$];
		int unsigned mismatches = 0;

		function bit is_num(logic [7:0] c);
			return c >= CH_0 && c <= CH_9;
		endfunction

		function bit is_alpha(logic [7:0] c);
			return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
		endfunction

		function void emit(logic [3:0] kind, int unsigned start, int unsigned len,
				logic [1:0] err);
			result_t r;
			r.kind = kind;
			r.start = start[15:0];
			r.length = len[11:0];
			r.err = err;
			r.last = 1'b0;
			expected_q.push_back(r);
		endfunction

		function void grow();
			if (run_len < TOKEN_LEN_CAP)
				run_len++;
		endfunction

		function void open_run(scan_state_t m, logic [7:0] c, int unsigned pos);
			mode = m;
			tok_begin = pos;
			run_len = 1;
			first_char = c;
		endfunction

		// identifiers are typed by their first letter alone
		function logic [3:0] word_kind(logic [7:0] c);
			case (c)
				CH_UC_I: return K_INTTYPE;
				CH_UC_S: return K_STRTYPE;
				CH_UC_J: return K_NULL;
				CH_LC_T: return K_TRUE;
				CH_LC_F: return K_FALSE;
				default: return K_IDENT;
			endcase
		endfunction

		// byte seen between tokens
		function void scan_start(logic [7:0] c, logic e, int unsigned pos);
			mode = ST_IDLE;
			case (c)
				CH_SPACE, CH_NL: return;
				CH_LBRACE: begin emit(K_LBRACE, pos, 1, ERR_NONE); return; end
				CH_RBRACE: begin emit(K_RBRACE, pos, 1, ERR_NONE); return; end
				CH_LSQ: begin emit(K_LSQUARE, pos, 1, ERR_NONE); return; end
				CH_RSQ: begin emit(K_RSQUARE, pos, 1, ERR_NONE); return; end
				CH_COLON: begin emit(K_COLON, pos, 1, ERR_NONE); return; end
				CH_COMMA: begin emit(K_COMMA, pos, 1, ERR_NONE); return; end
				CH_QUOTE: begin open_run(ST_STRING, c, pos); return; end
				default: ;
			endcase
			if (c == CH_MINUS || is_num(c)) begin
				open_run(ST_NUMBER, c, pos);
				return;
			end
			if (is_alpha(c)) begin
				open_run(ST_WORD, c, pos);
				return;
			end
			// anything else ends the text
			emit(K_END, pos, 0, ERR_NONE);
			if (e)
				offset = 0;
			else
				mode = ST_SKIP;
		endfunction

		// accepted input beat: advance state, queue the tokens it closes
		function void note_byte(logic [7:0] b, logic e);
			int unsigned pos;
			int unsigned n_before;
			logic [7:0] c;
			pos = offset;
			n_before = expected_q.size();
			if (mode == ST_STOPPED)
				return;
			if (mode == ST_SKIP) begin
				if (e) begin
					mode = ST_IDLE;
					offset = 0;
				end
				return;
			end
			c = (e || pos >= TEXT_LIMIT) ? CH_NUL : b;
			if (!e && offset < TEXT_LIMIT)
				offset++;
			case (mode)
				ST_STRING: begin
					if (c == CH_QUOTE) begin
						grow();
						emit(K_STRING, tok_begin, run_len, ERR_NONE);
						mode = ST_IDLE;
					end else if (c == CH_NUL) begin
						emit(K_STRING, tok_begin, run_len, ERR_UNTERM);
						mode = ST_STOPPED;
					end else begin
						grow();
					end
				end
				ST_NUMBER: begin
					if (is_num(c)) begin
						grow();
					end else if (run_len == 1 && first_char == CH_MINUS) begin
						emit(K_NUMBER, tok_begin, 1, ERR_MINUS);
						mode = ST_STOPPED;
					end else begin
						emit(K_NUMBER, tok_begin, run_len, ERR_NONE);
						scan_start(c, e, pos);
					end
				end
				ST_WORD: begin
					if (is_alpha(c) || c == CH_UNDER) begin
						grow();
					end else begin
						emit(word_kind(first_char), tok_begin, run_len, ERR_NONE);
						scan_start(c, e, pos);
					end
				end
				default: scan_start(c, e, pos);
			endcase
			if (expected_q.size() > n_before)
				expected_q[expected_q.size() - 1].last = 1'b1;
		endfunction

		// rewrite a beat that would halt the block into a harmless one
		function void steer_clear(inout logic [7:0] b, inout logic e);
			if (mode == ST_STRING && (e || b == CH_NUL)) begin
				b = CH_QUOTE;
				e = 1'b0;
			end else if (mode == ST_NUMBER && run_len == 1 && first_char == CH_MINUS &&
					(e || !is_num(b))) begin
				b = 8'(CH_0 + $urandom_range(9));
				e = 1'b0;
			end
		endfunction

		task report(string msg);
			mismatches++;
			$display("%0t ERROR %s", $realtime, msg);
		endtask

		// accepted token beat against the oldest expectation
		task check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected token kind=%0d start=%0d len=%0d err=%0d last=%0b",
					got.kind, got.start, got.length, got.err, got.last));
				return;
			end
			want = expected_q.pop_front();
			if (got !== want)
				report($sformatf({"token got kind=%0d start=%0d len=%0d err=%0d last=%0b",
					", want kind=%0d start=%0d len=%0d err=%0d last=%0b"},
					got.kind, got.start, got.length, got.err, got.last,
					want.kind, want.start, want.length, want.err, want.last));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        end_of_text;
	logic        empty;
	logic        pop;
	logic [3:0]  token_kind;
	logic [15:0] token_start;
	logic [11:0] token_len;
	logic [1:0]  error_code;
	logic        last_of_run;

	token_scoreboard sb = new;
	int unsigned send_idle_pct = 30;
	int unsigned recv_idle_pct = 47;
	int unsigned beats_sent = 0;
	int unsigned stall_cycles = 0;
	bit guard_errors = 1'b1;

	config_text_tokenizer_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.end_of_text  (end_of_text),
		.empty        (empty),
		.pop          (pop),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_len    (token_len),
		.error_code   (error_code),
		.last_of_run  (last_of_run)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// random character helpers
	function automatic logic [7:0] random_letter();
		int unsigned r;
		r = $urandom_range(51);
		return (r < 26) ? 8'(CH_UC_A + r) : 8'(CH_LC_A + r - 26);
	endfunction

	function automatic logic [7:0] word_tail_char();
		return ($urandom_range(7) == 0) ? CH_UNDER : random_letter();
	endfunction

	function automatic logic [7:0] string_body_char();
		logic [7:0] b;
		do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE);
		return b;
	endfunction

	// one input beat; the scoreboard sees it at the edge that takes it
	task automatic send_beat(input logic [7:0] b, input logic e);
		logic [7:0] db;
		logic de;
		db = b;
		de = e;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		if (guard_errors)
			sb.steer_clear(db, de);
		push <= 1'b1;
		data_byte <= db;
		end_of_text <= de;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_byte(db, de);
		beats_sent++;
	endtask

	// one well-formed token, sometimes behind whitespace
	task automatic send_token();
		int unsigned pick;
		int unsigned n;
		pick = $urandom_range(99);
		if ($urandom_range(3) == 0)
			send_beat($urandom_range(1) ? CH_SPACE : CH_NL, 1'b0);
		if (pick < 30) begin
			case ($urandom_range(5))
				0: send_beat(CH_LBRACE, 1'b0);
				1: send_beat(CH_RBRACE, 1'b0);
				2: send_beat(CH_LSQ, 1'b0);
				3: send_beat(CH_RSQ, 1'b0);
				4: send_beat(CH_COLON, 1'b0);
				default: send_beat(CH_COMMA, 1'b0);
			endcase
		end else if (pick < 50) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
			send_beat(CH_QUOTE, 1'b0);
			repeat (n) send_beat(string_body_char(), 1'b0);
			send_beat(CH_QUOTE, 1'b0);
		end else if (pick < 75) begin
			if ($urandom_range(2) == 0)
				send_beat(CH_MINUS, 1'b0);
			repeat ($urandom_range(1, 6)) send_beat(8'(CH_0 + $urandom_range(9)), 1'b0);
		end else begin
			if ($urandom_range(1)) begin
				case ($urandom_range(4))
					0: send_beat(CH_UC_I, 1'b0);
					1: send_beat(CH_UC_S, 1'b0);
					2: send_beat(CH_UC_J, 1'b0);
					3: send_beat(CH_LC_T, 1'b0);
					default: send_beat(CH_LC_F, 1'b0);
				endcase
			end else begin
				send_beat(random_letter(), 1'b0);
			end
			repeat ($urandom_range(7)) send_beat(word_tail_char(), 1'b0);
		end
	endtask

	// one text: mostly tokens and an ending, sometimes raw noise
	task automatic send_text();
		logic [7:0] odd;
		if ($urandom_range(99) < 15) begin
			repeat ($urandom_range(5, 30))
				send_beat(8'($urandom), 1'($urandom_range(9) == 0));
			// close whatever the noise left open
			while (sb.offset != 0 || sb.mode != ST_IDLE)
				send_beat(8'($urandom), 1'b1);
			return;
		end
		repeat ($urandom_range(1, 12)) send_token();
		case ($urandom_range(19))
			0, 1, 2: begin
				send_beat(CH_NUL, 1'b0);
				repeat ($urandom_range(4)) send_beat(8'($urandom), 1'b0);
			end
			3, 4, 5: begin
				odd = $urandom_range(1) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(1, 8));
				send_beat(odd, 1'b0);
				repeat ($urandom_range(4)) send_beat(8'($urandom), 1'b0);
			end
			default: ;
		endcase
		send_beat(8'($urandom), 1'b1);
	endtask

	// sender holds off until every expected token has been popped
	task automatic hold_until_drained();
		push <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
	endtask

	// result side: pop with random stalls, check every beat taken
	initial begin
		result_t got;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got.kind = token_kind;
				got.start = token_start;
				got.length = token_len;
				got.err = error_code;
				got.last = last_of_run;
				sb.check_result(got);
			end
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		string dir_text;
		push = 1'b0;
		data_byte = 8'h00;
		end_of_text = 1'b0;
		arst_n = 1'b0;
		dir_text = "{\"\":-5,[t,f\nI S J q_]}";
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: all punctuation, empty string, signed number, word kinds,
		// whitespace, end marker, zero byte, dropped bytes, high byte
		for (int i = 0; i < dir_text.len(); i++)
			send_beat(dir_text[i], 1'b0);
		send_beat(8'h5A, 1'b1);
		send_beat(CH_NUL, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'hA5, 1'b1);
		send_beat(8'h80, 1'b0);
		send_beat(8'h00, 1'b1);

		// random texts under three idle mixes
		while (beats_sent < 530) send_text();
		hold_until_drained();
		send_idle_pct = 47;
		recv_idle_pct = 30;
		while (beats_sent < 1060) send_text();
		hold_until_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (beats_sent < 1580) send_text();

		// finish on a halting error, then show that every beat is ignored
		guard_errors = 1'b0;
		send_beat(CH_LBRACE, 1'b0);
		if ($urandom_range(1) == 0) begin
			send_beat(CH_QUOTE, 1'b0);
			send_beat(CH_LC_A, 1'b0);
			send_beat(CH_UC_Z, 1'b0);
			if ($urandom_range(1))
				send_beat(8'($urandom), 1'b1);
			else
				send_beat(CH_NUL, 1'b0);
		end else begin
			send_beat(CH_MINUS, 1'b0);
			case ($urandom_range(2))
				0: send_beat(8'($urandom), 1'b1);
				1: send_beat(CH_SPACE, 1'b0);
				default: send_beat(CH_RBRACE, 1'b0);
			endcase
		end
		repeat (16) send_beat(8'($urandom), 1'($urandom_range(1)));
		push <= 1'b0;

		// wait out the last tokens, then a margin for stray beats
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
